// ===== hw/rtl/mppt_po_pkg.sv =====
package mppt_po_pkg;

   // field widths
   localparam int SAMPLE_W = 12;
   localparam int AVG_W    = 12;
   localparam int POWER_W  = 24;
   localparam int DUTY_W   = 9;
   localparam int STEP_W   = 9;
   localparam int CSR_IDX_W = 1;

   // packed stream widths, padded to whole bytes
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 64;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_STEP_SIZE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_START_DUTY = 1'b1;

   // duty limits, one bit wider than the duty so a raised candidate fits
   localparam logic [DUTY_W:0]   DUTY_WRAP_LIMIT = 10'd350;
   localparam logic [DUTY_W:0]   DUTY_HIGH_LIMIT = 10'd320;
   localparam logic [DUTY_W-1:0] DUTY_FALLBACK   = 9'd310;
   localparam logic [DUTY_W-1:0] DUTY_START_MAX  = 9'd320;

   // reset values
   localparam logic [STEP_W-1:0] STEP_RESET = 9'd1;
   localparam logic [DUTY_W-1:0] DUTY_RESET = 9'd0;

   // average saturation
   localparam logic [AVG_W-1:0] AVG_MAX = 12'hFFF;

endpackage

// ===== hw/rtl/mppt_perturb_observe_tracker_top.sv =====
// Perturb-and-observe maximum power point tracker.
// req channel: one current/voltage sample pair per request. A group of PAIRS
// pairs is summed; on the last pair of a group the two averages are formed
// (sum >> AVG_SHIFT, saturated at 4095).
// rsp channel: one result per group with the new duty cycle, both averages,
// their product as power and the tracking direction.
// csr channel: index 0 step_size, index 1 start_duty; writing start_duty also
// presets the duty cycle (saturated at 320). Ready except in a cycle where a
// group result updates the tracker; write only while the tracker is idle.
// The result of a group moves from the average register, loaded when the
// last pair of its group is accepted, to the power register and then to the
// result register; the multiplier has a stage of its own.
// Throughput: one pair per cycle while the last pair of a group is not held
// off; each register of the three-deep chain carries one group result.
// Reset clears the pair count, sums, previous power and pipeline valids, sets
// direction up, step_size to 1 and the duty cycle to 0.
// When rsp_tready is low the result register holds; pairs that do not close a
// group are still accepted, and the last pair of a group is held off only
// while the average and power registers are both full behind a stalled result.
module mppt_perturb_observe_tracker_top
   import mppt_po_pkg::*;
#(
   parameter int PAIRS       = 8,
   parameter int AVG_SHIFT   = 4,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [11:0] sample_current, [23:12] sample_voltage
   input  logic [REQ_DATA_W-1:0]  req_tdata,

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [8:0] duty, [20:9] volt_mean, [32:21] curr_mean,
   // [56:33] power_now, [57] increasing, [63:58] zero
   output logic [RSP_DATA_W-1:0]  rsp_tdata,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [STEP_W-1:0]      csr_data
);

   localparam int USE_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam int SUM_W    = USE_BITS + $clog2(PAIRS);
   localparam int EXT_W    = (SUM_W > AVG_W) ? SUM_W : AVG_W;
   localparam int CNT_W    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(PAIRS - 1);

   // configuration and tracking state
   logic [STEP_W-1:0]  step_ff;
   logic [DUTY_W-1:0]  duty_now_ff, duty_now_in;
   logic               dir_ff, dir_in;
   logic [POWER_W-1:0] prev_power_ff;

   // accumulator
   logic [CNT_W-1:0]   cnt_ff;
   logic [SUM_W-1:0]   cur_sum_ff, vol_sum_ff;
   logic [SUM_W-1:0]   cur_total, vol_total;
   logic [EXT_W-1:0]   cur_shr, vol_shr;
   logic [AVG_W-1:0]   cur_avg_in, vol_avg_in;

   // average stage
   logic               s1_valid_ff;
   logic [AVG_W-1:0]   s1_cur_ff, s1_vol_ff;

   // power stage
   logic               s2_valid_ff;
   logic [AVG_W-1:0]   s2_cur_ff, s2_vol_ff;
   logic [POWER_W-1:0] s2_power_ff;

   // result register
   logic               rsp_valid_ff;
   logic [DUTY_W-1:0]  rsp_duty_ff;
   logic [AVG_W-1:0]   rsp_cur_ff, rsp_vol_ff;
   logic [POWER_W-1:0] rsp_power_ff;
   logic               rsp_dir_ff;

   // handshake
   logic req_fire, last_pair, s3_free, s2_free, s1_free, s2_move, s1_move;
   logic [DUTY_W:0] up_sum;

   // stage flow control
   assign s3_free    = !rsp_valid_ff || rsp_tready;
   assign s2_move    = s2_valid_ff && s3_free;
   assign s2_free    = !s2_valid_ff || s3_free;
   assign s1_move    = s1_valid_ff && s2_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign last_pair  = (cnt_ff == LAST_CNT);
   assign req_tready = s1_free || !last_pair;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = !s2_move;

   // running sums and group averages
   always_comb begin
      cur_total  = cur_sum_ff + SUM_W'(req_tdata[USE_BITS-1:0]);
      vol_total  = vol_sum_ff + SUM_W'(req_tdata[SAMPLE_W+USE_BITS-1:SAMPLE_W]);
      cur_shr    = EXT_W'(cur_total) >> AVG_SHIFT;
      vol_shr    = EXT_W'(vol_total) >> AVG_SHIFT;
      cur_avg_in = (cur_shr > EXT_W'(AVG_MAX)) ? AVG_MAX : cur_shr[AVG_W-1:0];
      vol_avg_in = (vol_shr > EXT_W'(AVG_MAX)) ? AVG_MAX : vol_shr[AVG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         cur_sum_ff <= '0;
         vol_sum_ff <= '0;
      end else if (req_fire) begin
         if (last_pair) begin
            cnt_ff     <= '0;
            cur_sum_ff <= '0;
            vol_sum_ff <= '0;
         end else begin
            cnt_ff     <= cnt_ff + CNT_W'(1);
            cur_sum_ff <= cur_total;
            vol_sum_ff <= vol_total;
         end
      end
   end

   // average register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= req_fire && last_pair;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free && req_fire && last_pair) begin
         s1_cur_ff <= cur_avg_in;
         s1_vol_ff <= vol_avg_in;
      end
   end

   // power register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_cur_ff   <= s1_cur_ff;
         s2_vol_ff   <= s1_vol_ff;
         s2_power_ff <= POWER_W'(s1_vol_ff) * POWER_W'(s1_cur_ff);
      end
   end

   // perturb-and-observe step
   always_comb begin
      dir_in = (s2_power_ff < prev_power_ff) ? !dir_ff : dir_ff;
      up_sum = {1'b0, duty_now_ff} + {1'b0, step_ff};
      if (dir_in) begin
         if (up_sum > DUTY_WRAP_LIMIT) begin
            duty_now_in = '0;
         end else if (up_sum > DUTY_HIGH_LIMIT) begin
            duty_now_in = DUTY_FALLBACK;
         end else begin
            duty_now_in = up_sum[DUTY_W-1:0];
         end
      end else begin
         if (step_ff > duty_now_ff) begin
            duty_now_in = '0;
         end else begin
            duty_now_in = duty_now_ff - step_ff;
         end
      end
   end

   // tracking state and register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= STEP_RESET;
         duty_now_ff   <= DUTY_RESET;
         dir_ff        <= 1'b1;
         prev_power_ff <= '0;
      end else if (s2_move) begin
         duty_now_ff   <= duty_now_in;
         dir_ff        <= dir_in;
         prev_power_ff <= s2_power_ff;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_STEP_SIZE: begin
               step_ff <= csr_data;
            end
            REG_START_DUTY: begin
               duty_now_ff <= (csr_data > DUTY_START_MAX) ? DUTY_START_MAX : csr_data;
            end
            default: begin
               step_ff <= step_ff;
            end
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s3_free) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move) begin
         rsp_duty_ff  <= duty_now_in;
         rsp_cur_ff   <= s2_cur_ff;
         rsp_vol_ff   <= s2_vol_ff;
         rsp_power_ff <= s2_power_ff;
         rsp_dir_ff   <= dir_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_dir_ff, rsp_power_ff, rsp_cur_ff, rsp_vol_ff,
                        rsp_duty_ff};

`ifndef SYNTHESIS
   // a shown duty never leaves the legal range
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({1'b0, rsp_duty_ff} <= DUTY_HIGH_LIMIT))
      else $error("duty cycle above limit");

   // shown power is the product of the shown averages
   a_power_product: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_power_ff == POWER_W'(rsp_vol_ff) * POWER_W'(rsp_cur_ff)))
      else $error("power does not match averages");

   // the last pair of a group always lands in the average register
   a_group_close: assert property (@(posedge clock) disable iff (reset)
      (req_fire && last_pair) |=> s1_valid_ff)
      else $error("closed group lost");

   // shown direction is the tracker's current direction
   a_dir_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_dir_ff == dir_ff))
      else $error("direction mismatch");
`endif

endmodule
